// ===== rtl/core/mgpl_pkg.sv =====
// Shared types and constants for the mirrored gradient palette lookup.
package mgpl_pkg;

    localparam int MAX_STOPS  = 5;
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 24;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int SQ_W       = 16;
    localparam int FRAC_STEPS = 8;

    localparam logic [POS_W-1:0] FOLD_POS = 8'd128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STOP0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POS2  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POS3  = 3'd7;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [SQ_W-1:0]   t_sq;

    // Colors riding alongside the divider chain.
    typedef struct packed {
        logic             full;
        t_chan [2:0]      ca;
        t_chan [2:0]      cb;
    } t_seg_sb;

endpackage

// ===== rtl/core/mgpl_div_cell.sv =====
// One restoring-division cell: produces one fraction bit of k*256/len.
module mgpl_div_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [mgpl_pkg::POS_W-1:0]    i_rem,
    input  logic [mgpl_pkg::POS_W-1:0]    i_len,
    input  logic [mgpl_pkg::POS_W-1:0]    i_q,
    output logic [mgpl_pkg::POS_W-1:0]    o_rem,
    output logic [mgpl_pkg::POS_W-1:0]    o_len,
    output logic [mgpl_pkg::POS_W-1:0]    o_q
);
    logic [mgpl_pkg::POS_W:0]   sh;
    logic                       ge;
    logic [mgpl_pkg::POS_W-1:0] n_rem;

    always_comb begin
        sh    = {i_rem, 1'b0};
        ge    = sh >= {1'b0, i_len};
        n_rem = ge ? mgpl_pkg::POS_W'(sh - {1'b0, i_len}) : sh[mgpl_pkg::POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_len <= i_len;
            o_q   <= {i_q[mgpl_pkg::POS_W-2:0], ge};
        end
    end
endmodule

// ===== rtl/core/mgpl_sqrt_cell.sv =====
// One digit-by-digit square root cell: one root bit per cycle while i_en is high.
module mgpl_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [8:0]                    i_rem,
    input  logic [mgpl_pkg::CHAN_W-1:0]   i_root,
    input  logic [mgpl_pkg::SQ_W-1:0]     i_v,
    output logic [8:0]                    o_rem,
    output logic [mgpl_pkg::CHAN_W-1:0]   o_root,
    output logic [mgpl_pkg::SQ_W-1:0]     o_v
);
    logic [10:0] cur;
    logic [10:0] trial;
    logic        ge;

    always_comb begin
        cur   = {i_rem, i_v[mgpl_pkg::SQ_W-1 -: 2]};
        trial = {1'b0, i_root, 2'b01};
        ge    = cur >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= ge ? 9'(cur - trial) : cur[8:0];
            o_root <= {i_root[mgpl_pkg::CHAN_W-2:0], ge};
            o_v    <= {i_v[mgpl_pkg::SQ_W-3:0], 2'b00};
        end
    end
endmodule

// ===== rtl/core/mirrored_gradient_palette_lookup.sv =====
// Top level of the mirrored gradient palette lookup pipeline.
//
// Usage:
//  - Input channel: i_valid / o_stall carry i_entry_index (0..255). A request
//    is taken at a clock edge with i_valid high and o_stall low. Indices
//    above 128 fold back to 256 minus the index.
//  - Output channel: o_valid / i_stall carry o_red, o_green, o_blue.
//  - Config channel: i_cfg_valid / o_cfg_ready (always ready) with
//    i_cfg_index 0..4 = stop colors, 5..7 = stop positions. Write only
//    while the pipeline is empty.
//  - Path: stage 0, divider chain, smoothstep stages, root chain. One request
//    per cycle when not stalled, set by the single-bit cells of the divider
//    chain (8 cells for the smoothstep fraction) and the root chain (8 cells).
//  - Stall: when the output holds a result and i_stall is high, the whole
//    pipeline freezes and o_stall goes high in the same cycle.
//  - Reset: synchronous, active low; empties the pipeline and loads the
//    default black-to-white ramp with stops at 32, 64 and 96.
module mirrored_gradient_palette_lookup #(
    parameter int NUM_STOPS = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_entry_index,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mgpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mgpl_pkg::RGB_W-1:0]         i_cfg_data
);
    localparam int NSEG  = NUM_STOPS - 1;
    localparam int DIV_N = mgpl_pkg::FRAC_STEPS;
    localparam int SQ_N  = mgpl_pkg::CHAN_W;
    localparam int PIPE  = 1 + DIV_N + 4 + SQ_N;
    localparam int PW    = mgpl_pkg::POS_W;

    // ---------------- configuration registers ----------------
    logic [mgpl_pkg::RGB_W-1:0] r_stop [mgpl_pkg::MAX_STOPS];
    logic [PW-1:0]              r_pos  [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop[0] <= 24'h000000;
            r_stop[1] <= 24'h404040;
            r_stop[2] <= 24'h808080;
            r_stop[3] <= 24'hC0C0C0;
            r_stop[4] <= 24'hFFFFFF;
            r_pos[0]  <= 8'd32;
            r_pos[1]  <= 8'd64;
            r_pos[2]  <= 8'd96;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mgpl_pkg::CFG_STOP0: begin r_stop[0] <= i_cfg_data; end
                mgpl_pkg::CFG_STOP1: begin r_stop[1] <= i_cfg_data; end
                mgpl_pkg::CFG_STOP2: begin r_stop[2] <= i_cfg_data; end
                mgpl_pkg::CFG_STOP3: begin r_stop[3] <= i_cfg_data; end
                mgpl_pkg::CFG_STOP4: begin r_stop[4] <= i_cfg_data; end
                mgpl_pkg::CFG_POS1:  begin r_pos[0]  <= i_cfg_data[PW-1:0]; end
                mgpl_pkg::CFG_POS2:  begin r_pos[1]  <= i_cfg_data[PW-1:0]; end
                mgpl_pkg::CFG_POS3:  begin r_pos[2]  <= i_cfg_data[PW-1:0]; end
                default: begin end
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Whole pipeline moves together; it only freezes on a held output.
    logic            en;
    logic [PIPE-1:0] r_vld;

    assign en      = !(r_vld[PIPE-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE-2:0], i_valid};
        end
    end

    // ---------------- stage 0: fold, stop positions, segment ----------------
    logic [PW-1:0]              j;
    logic [PW-1:0]              pos [NUM_STOPS];
    logic [mgpl_pkg::RGB_W-1:0] col [NUM_STOPS];
    logic [2:0]                 seg;
    logic                       found;
    logic                       full;
    logic [PW-1:0]              seg_a;
    logic [PW-1:0]              seg_len;
    logic [mgpl_pkg::RGB_W-1:0] col_a;
    logic [mgpl_pkg::RGB_W-1:0] col_b;
    logic [PW-1:0]              p_lim;
    mgpl_pkg::t_seg_sb          n_sb;

    always_comb begin
        j = (i_entry_index > mgpl_pkg::FOLD_POS) ?
            PW'(9'd256 - {1'b0, i_entry_index}) : i_entry_index;
        p_lim = '0;
        for (int s = 0; s < NUM_STOPS; s++) begin
            col[s] = (s == NUM_STOPS - 1) ? r_stop[4] : r_stop[s];
            if (s == 0) begin
                pos[s] = '0;
            end else if (s == NUM_STOPS - 1) begin
                pos[s] = mgpl_pkg::FOLD_POS;
            end else begin
                p_lim  = (r_pos[s-1] > mgpl_pkg::FOLD_POS) ? mgpl_pkg::FOLD_POS
                                                           : r_pos[s-1];
                pos[s] = (p_lim < pos[s-1]) ? pos[s-1] : p_lim;
            end
        end
        full  = (j == mgpl_pkg::FOLD_POS);
        seg   = '0;
        found = 1'b0;
        for (int s = 0; s < NSEG; s++) begin
            if (!found && pos[s] <= j && j < pos[s+1]) begin
                seg   = 3'(s);
                found = 1'b1;
            end
        end
        // Fold index: blend fully into the last stop.
        if (full) begin
            seg = 3'(NSEG - 1);
        end
        seg_a   = pos[seg];
        seg_len = PW'(pos[seg+1] - seg_a);
        col_a   = col[seg];
        col_b   = col[seg+1];
        n_sb.full = full;
        for (int c = 0; c < 3; c++) begin
            n_sb.ca[c] = col_a[16 - 8*c +: 8];
            n_sb.cb[c] = col_b[16 - 8*c +: 8];
        end
    end

    logic [PW-1:0]     r_k;
    logic [PW-1:0]     r_len;
    mgpl_pkg::t_seg_sb r_sb0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k   <= PW'(j - seg_a);
            r_len <= seg_len;
            r_sb0 <= n_sb;
        end
    end

    // ---------------- divider chain: t = k*256/len ----------------
    logic [PW-1:0]     w_rem [DIV_N+1];
    logic [PW-1:0]     w_len [DIV_N+1];
    logic [PW-1:0]     w_q   [DIV_N+1];
    mgpl_pkg::t_seg_sb r_dsb [DIV_N];

    assign w_rem[0] = r_k;
    assign w_len[0] = r_len;
    assign w_q[0]   = '0;

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        mgpl_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (w_rem[g]),
            .i_len (w_len[g]),
            .i_q   (w_q[g]),
            .o_rem (w_rem[g+1]),
            .o_len (w_len[g+1]),
            .o_q   (w_q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsb[0] <= r_sb0;
            for (int s = 1; s < DIV_N; s++) begin
                r_dsb[s] <= r_dsb[s-1];
            end
        end
    end

    // ---------------- smoothstep and squares ----------------
    mgpl_pkg::t_sq [2:0] r_sqa1, r_sqb1, r_sqa2, r_sqb2, r_sqa3;
    logic [7:0]          r_t1, r_tt1;
    logic                r_full1;
    logic [8:0]          r_e2;
    logic [2:0]          r_ge3;
    logic [24:0]         r_prod3 [3];
    mgpl_pkg::t_sq [2:0] r_v4;
    logic [9:0]          w_wt;
    logic [17:0]         w_ep;
    logic [15:0]         w_dif [3];
    logic [15:0]         w_d   [3];

    always_comb begin
        w_wt = 10'(10'd768 - {1'b0, r_t1, 1'b0});
        w_ep = 18'(r_tt1) * 18'(w_wt);
        for (int c = 0; c < 3; c++) begin
            w_dif[c] = (r_sqb2[c] >= r_sqa2[c]) ? 16'(r_sqb2[c] - r_sqa2[c])
                                                : 16'(r_sqa2[c] - r_sqb2[c]);
            w_d[c]   = 16'((26'(r_prod3[c]) + 26'd255) >> 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // t, t*t/256 and squared stop channels
            r_t1    <= w_q[DIV_N];
            r_tt1   <= 8'((16'(w_q[DIV_N]) * 16'(w_q[DIV_N])) >> 8);
            r_full1 <= r_dsb[DIV_N-1].full;
            for (int c = 0; c < 3; c++) begin
                r_sqa1[c] <= 16'(r_dsb[DIV_N-1].ca[c]) * 16'(r_dsb[DIV_N-1].ca[c]);
                r_sqb1[c] <= 16'(r_dsb[DIV_N-1].cb[c]) * 16'(r_dsb[DIV_N-1].cb[c]);
            end
            // weight e
            r_e2   <= r_full1 ? 9'd256 : 9'(w_ep >> 8);
            r_sqa2 <= r_sqa1;
            r_sqb2 <= r_sqb1;
            // channel difference times weight
            for (int c = 0; c < 3; c++) begin
                r_ge3[c]   <= r_sqb2[c] >= r_sqa2[c];
                r_prod3[c] <= 25'(w_dif[c]) * 25'(r_e2);
            end
            r_sqa3 <= r_sqa2;
            // blended squared value, floored toward minus infinity
            for (int c = 0; c < 3; c++) begin
                if (r_ge3[c]) begin
                    r_v4[c] <= 16'(r_sqa3[c] + 16'(r_prod3[c] >> 8));
                end else begin
                    r_v4[c] <= (w_d[c] > r_sqa3[c]) ? '0 : 16'(r_sqa3[c] - w_d[c]);
                end
            end
        end
    end

    // ---------------- square root chains, one per channel ----------------
    logic [7:0] w_root [3];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [8:0]  s_rem  [SQ_N+1];
        logic [7:0]  s_root [SQ_N+1];
        logic [15:0] s_v    [SQ_N+1];

        assign s_rem[0]  = '0;
        assign s_root[0] = '0;
        assign s_v[0]    = r_v4[c];

        for (genvar g = 0; g < SQ_N; g++) begin : g_cell
            mgpl_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_rem  (s_rem[g]),
                .i_root (s_root[g]),
                .i_v    (s_v[g]),
                .o_rem  (s_rem[g+1]),
                .o_root (s_root[g+1]),
                .o_v    (s_v[g+1])
            );
        end

        assign w_root[c] = s_root[SQ_N];
    end

    assign o_red   = w_root[0];
    assign o_green = w_root[1];
    assign o_blue  = w_root[2];

`ifndef ASSERT_OFF
    a_stall_only_on_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    a_take_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted request lost at pipeline entry");
`endif
endmodule
